// ----- rtl/kwm_pkg.sv -----
// Shared constants and types for the k-way sorted merge block.
`default_nettype none

package kwm_pkg;

   // Geometry of the list store.
   localparam int NUM_LISTS  = 8;
   localparam int LIST_DEPTH = 64;
   localparam int LIST_W     = $clog2(NUM_LISTS);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int SCAN_W     = $clog2(NUM_LISTS);
   localparam int DATA_W     = 32;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_PULL  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_LOADED  = 3'd0,
      ST_DROPPED = 3'd1,
      ST_POPPED  = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_CLEARED = 3'd4
   } status_type;

   // Running minimum handed from one list cell to the next.
   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] value;
      logic [LIST_W-1:0]        idx;
   } token_type;

   // Per-cell commands from the controller.
   typedef struct packed {
      logic              wr;
      logic              adv;
      logic              clr;
      logic [DATA_W-1:0] wdata;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/kwm_cell.sv -----
// One list cell: stores one list, tracks its fill and read positions, updates the minimum.
`default_nettype none

module kwm_cell
   import kwm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [LIST_W-1:0] cell_idx,
   input  cell_cmd_type      cmd,
   input  token_type         tok_in,
   output token_type         tok_out,
   output logic              full
);

   logic [DATA_W-1:0]        mem [LIST_DEPTH];
   logic signed [DATA_W-1:0] head_ff;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         rdpos_ff, rdpos_in;
   token_type                chain_ff, chain_in;
   logic                     nonempty;

   assign nonempty = (rdpos_ff != fill_ff);
   assign full     = (fill_ff == CNT_W'(LIST_DEPTH));
   assign tok_out  = chain_ff;

   // Replace the incoming minimum only when this head is strictly smaller,
   // so on a tie the lower list number keeps the win.
   always_comb begin
      chain_in = tok_in;
      if (nonempty && (!tok_in.found || (head_ff < tok_in.value))) begin
         chain_in.found = 1'b1;
         chain_in.value = head_ff;
         chain_in.idx   = cell_idx;
      end
   end

   // Fill and read positions.
   always_comb begin
      fill_in  = fill_ff;
      rdpos_in = rdpos_ff;
      if (cmd.clr) begin
         fill_in  = '0;
         rdpos_in = '0;
      end else begin
         if (cmd.wr) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         if (cmd.adv) begin
            rdpos_in = rdpos_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rdpos_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         rdpos_ff <= rdpos_in;
      end
   end

   // Chain register toward the next cell.
   always_ff @(posedge clock) begin
      chain_ff <= chain_in;
   end

   // List storage: append at the fill position, head read at the read position.
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[fill_ff[ADDR_W-1:0]] <= cmd.wdata;
      end
      head_ff <= mem[rdpos_ff[ADDR_W-1:0]];
   end

endmodule

`default_nettype wire

// ----- rtl/k_way_sorted_merge.sv -----
// Top level of the k-way sorted merge: request decode, list cell chain and response register.
`default_nettype none

// Holds NUM_LISTS ascending lists of LIST_DEPTH signed words and merges them on demand.
// A load request appends a value to one list (dropped if the list is full or out of range),
// a pull request returns the smallest list head with ties going to the lower list number,
// and a clear request empties every list. One request is handled at a time. A load or
// clear goes from acceptance straight to the finish state; a pull first waits in the scan
// state while the running minimum walks the chain of list cells one cell per cycle, and
// the response is registered on commit. A new request is accepted while the previous
// response still waits to be taken; a response that is still not taken when the next
// one is ready stalls the block until the output register frees.

module k_way_sorted_merge
   import kwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // op[1:0], list_num[4:2], value[36:5], zero fill
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[2:0], merged_value[34:3], source_list[37:35]
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      FINISH
   } state_type;

   state_type         state_ff;
   logic [SCAN_W-1:0] cnt_ff;
   logic [1:0]        op_ff;
   logic [2:0]        ln_ff;
   logic [DATA_W-1:0] val_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]        rsp_src_ff, rsp_src_in;

   token_type              tok [NUM_LISTS+1];
   cell_cmd_type           cmd [NUM_LISTS];
   logic [NUM_LISTS-1:0]   full_vec;
   logic [NUM_LISTS-1:0]   load_hit;
   logic [NUM_LISTS-1:0]   wr_vec;
   logic [NUM_LISTS-1:0]   adv_vec;
   logic                   req_accept;
   logic                   out_free;
   logic                   commit;
   logic                   in_range;
   logic                   load_ok;
   token_type              best;

   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == FINISH) && out_free;
   assign in_range   = (32'(ln_ff) < NUM_LISTS);
   assign load_ok    = |load_hit;
   assign best       = tok[NUM_LISTS];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_src_ff, rsp_value_ff, rsp_status_ff};

   // The chain starts with no candidate.
   assign tok[0] = '0;

   // Cell commands and the chain of list cells.
   for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
      assign load_hit[i] = in_range && (32'(ln_ff) == i) && !full_vec[i];
      assign wr_vec[i]   = commit && (op_ff == OP_LOAD) && load_hit[i];
      assign adv_vec[i]  = commit && (op_ff == OP_PULL) && best.found
                           && (32'(best.idx) == i);

      always_comb begin
         cmd[i].wr    = wr_vec[i];
         cmd[i].adv   = adv_vec[i];
         cmd[i].clr   = commit && (op_ff == OP_CLEAR);
         cmd[i].wdata = val_ff;
      end

      kwm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (LIST_W'(i)),
         .cmd      (cmd[i]),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1]),
         .full     (full_vec[i])
      );
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_tdata[1:0];
         ln_ff  <= req_tdata[4:2];
         val_ff <= req_tdata[36:5];
      end
   end

   // Response contents for the request being committed; the unused operation sends none.
   always_comb begin
      rsp_valid_in  = 1'b1;
      rsp_status_in = ST_LOADED;
      rsp_value_in  = '0;
      rsp_src_in    = '0;
      unique case (op_ff)
         OP_LOAD: begin
            rsp_status_in = load_ok ? ST_LOADED : ST_DROPPED;
         end
         OP_PULL: begin
            if (best.found) begin
               rsp_status_in = ST_POPPED;
               rsp_value_in  = best.value;
               rsp_src_in    = 3'(best.idx);
            end else begin
               rsp_status_in = ST_EMPTY;
            end
         end
         OP_CLEAR: begin
            rsp_status_in = ST_CLEARED;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Controller: scan timing, commit and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               cnt_ff <= '0;
               if (req_accept) begin
                  if (req_tdata[1:0] == OP_PULL) begin
                     state_ff <= SCAN;
                  end else begin
                     state_ff <= FINISH;
                  end
               end
            end
            SCAN: begin
               // Scan until the running minimum has passed through the last cell.
               if (cnt_ff == SCAN_W'(NUM_LISTS - 1)) begin
                  state_ff <= FINISH;
               end else begin
                  cnt_ff <= cnt_ff + SCAN_W'(1);
               end
            end
            FINISH: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         // Load the response register on commit, otherwise empty it once taken.
         if (commit) begin
            rsp_valid_ff  <= rsp_valid_in;
            rsp_status_ff <= rsp_status_in;
            rsp_value_ff  <= rsp_value_in;
            rsp_src_ff    <= rsp_src_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A response appears only when a request is committed.
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == FINISH))
      else $error("response raised without a committed request");

   // At most one list is appended to or advanced per request.
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_vec) && $onehot0(adv_vec))
      else $error("more than one list cell updated");

   // Only a pull commit advances a list, and never together with a write.
   a_adv_only_pull: assert property (@(posedge clock) disable iff (reset)
      (|adv_vec) |-> (commit && (op_ff == OP_PULL) && !(|wr_vec)))
      else $error("list advanced outside a pull commit");

   // Non-pop responses carry zero value and source.
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != ST_POPPED)) |-> (rsp_tdata[37:3] == '0))
      else $error("non-pop response carries payload");

endmodule

`default_nettype wire

// ----- tb/tb_k_way_sorted_merge.sv -----
// Self-checking testbench for the k-way sorted merge: directed table, then randomized list merges.

module tb_k_way_sorted_merge;
   import kwm_pkg::*;

   // Unused operation code: the block ignores it and sends no response.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int TARGET_ITEMS   = 1950;
   localparam int DIRECTED_ROWS  = 25;
   localparam int IDLE_PERCENT   = 17;
   localparam int MAX_GAP        = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 3 * (NUM_LISTS + 2);
   localparam int MAX_REPORTS    = 40;

   // One response as the block should produce it.
   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] merged_value;
      logic [LIST_W-1:0]        source_list;
   } merge_result_type;

   // One row of the directed table; typed rows carry their own expected response.
   typedef struct packed {
      logic [1:0]        op;
      logic [LIST_W-1:0] list_num;
      logic [DATA_W-1:0] value;
      bit                typed;
      merge_result_type  res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // Mirror of the list store used to work out expected responses.
   logic signed [DATA_W-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
   int unsigned              fill_lvl [NUM_LISTS];
   int unsigned              head_pos [NUM_LISTS];

   merge_result_type pending_results[$];

   int  error_count    = 0;
   int  accepted_items = 0;
   int  ignored_items  = 0;
   int  quiet_cycles   = 0;
   int  loads_seen     = 0;
   int  drops_seen     = 0;
   int  pops_seen      = 0;
   int  empties_seen   = 0;
   int  clears_seen    = 0;
   bit  calm           = 1'b0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY,   32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd0, 32'h7FFF_FFFF, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd7, 32'h8000_0000, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd3, 32'h0000_0005, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd3, 32'h0000_0005, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd1, 32'h0000_0005, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd4, 32'h0000_0000, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd4, 32'hFFFF_FFFF, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_POPPED,  32'h8000_0000, 3'd7}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_LOAD,   3'd7, 32'hFFFF_FC18, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_UNUSED, 3'd5, 32'hA5A5_A5A5, 1'b0, '0},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b0, '0},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_POPPED,  32'h7FFF_FFFF, 3'd0}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY,   32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd2, 32'h5555_5555, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_CLEAR,  3'd0, 32'h0000_0000, 1'b1, '{ST_CLEARED, 32'h0000_0000, 3'd0}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY,   32'h0000_0000, 3'd0}},
      '{OP_LOAD,   3'd6, 32'h1234_5678, 1'b1, '{ST_LOADED,  32'h0000_0000, 3'd0}},
      '{OP_PULL,   3'd0, 32'h0000_0000, 1'b1, '{ST_POPPED,  32'h1234_5678, 3'd6}},
      '{OP_CLEAR,  3'd0, 32'h0000_0000, 1'b1, '{ST_CLEARED, 32'h0000_0000, 3'd0}}
   };

   k_way_sorted_merge DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one mismatch line (up to a cap) and counts it.
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // Applies one request to the mirrored lists; returns 0 when no response follows.
   function automatic bit predict_merge(input logic [1:0] op, input logic [LIST_W-1:0] lst,
                                        input logic signed [DATA_W-1:0] val,
                                        output merge_result_type res);
      bit                       found;
      int                       best;
      logic signed [DATA_W-1:0] best_val;
      found    = 1'b0;
      best     = 0;
      best_val = '0;
      res      = '{ST_LOADED, '0, '0};
      case (op)
         OP_LOAD: begin
            if (int'(lst) >= NUM_LISTS || fill_lvl[lst] >= LIST_DEPTH) begin
               res.status = ST_DROPPED;
            end else begin
               list_mem[lst][fill_lvl[lst]] = val;
               fill_lvl[lst]++;
            end
            return 1'b1;
         end
         OP_PULL: begin
            // Strict compare keeps the lowest list number on ties.
            for (int i = 0; i < NUM_LISTS; i++) begin
               if (head_pos[i] < fill_lvl[i]) begin
                  if (!found || list_mem[i][head_pos[i]] < best_val) begin
                     found    = 1'b1;
                     best     = i;
                     best_val = list_mem[i][head_pos[i]];
                  end
               end
            end
            if (!found) begin
               res.status = ST_EMPTY;
            end else begin
               head_pos[best]++;
               res.status       = ST_POPPED;
               res.merged_value = best_val;
               res.source_list  = LIST_W'(best);
            end
            return 1'b1;
         end
         OP_CLEAR: begin
            for (int i = 0; i < NUM_LISTS; i++) begin
               fill_lvl[i] = 0;
               head_pos[i] = 0;
            end
            res.status = ST_CLEARED;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Sends one request, with an optional random gap before it, and records what it should return.
   task automatic send_request(input logic [1:0] op, input logic [LIST_W-1:0] lst,
                               input logic [DATA_W-1:0] val, input bit typed,
                               input merge_result_type typed_res);
      merge_result_type res;
      bit               has_res;
      if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, val, lst, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      has_res = predict_merge(op, lst, val, res);
      if (has_res) begin
         if (typed) begin
            res = typed_res;
         end
         pending_results = {pending_results, res};
         accepted_items++;
      end else begin
         ignored_items++;
      end
   endtask

   // Holds the request side low until every expected response has been taken.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Random ascending starting point, biased toward the ends and the middle of the signed range.
   function automatic logic signed [DATA_W-1:0] pick_start();
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return $urandom;
         2:       return int'($urandom_range(0, 200)) - 100;
         default: return 32'h7FFF_FFF0;
      endcase
   endfunction

   // Next value of an ascending list: repeats, small steps and large jumps, saturated at the top.
   function automatic logic signed [DATA_W-1:0] next_sorted(input logic signed [DATA_W-1:0] prev);
      longint nxt;
      case ($urandom_range(0, 3))
         0:       nxt = longint'(prev);
         1:       nxt = longint'(prev) + longint'($urandom);
         default: nxt = longint'(prev) + longint'($urandom_range(1, 1000));
      endcase
      if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
      return nxt[DATA_W-1:0];
   endfunction

   // Loads ascending values into random lists, with a few early pulls, then merges them out and usually clears.
   task automatic run_merge_round();
      logic signed [DATA_W-1:0] last_val [NUM_LISTS];
      int                       n_loads;
      int                       n_pulls;
      int                       lst;
      for (int i = 0; i < NUM_LISTS; i++) last_val[i] = pick_start();
      n_loads = $urandom_range(3, 40);
      for (int k = 0; k < n_loads; k++) begin
         lst           = $urandom_range(0, NUM_LISTS - 1);
         last_val[lst] = next_sorted(last_val[lst]);
         send_request(OP_LOAD, LIST_W'(lst), last_val[lst], 1'b0, '0);
         if ($urandom_range(0, 7) == 0) send_request(OP_PULL, '0, $urandom, 1'b0, '0);
      end
      n_pulls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n_loads) :
                n_loads + $urandom_range(1, 2);
      for (int k = 0; k < n_pulls; k++) send_request(OP_PULL, '0, $urandom, 1'b0, '0);
      if ($urandom_range(0, 4) != 0) begin
         send_request(OP_CLEAR, LIST_W'($urandom), $urandom, 1'b0, '0);
      end
   endtask

   // Fills one list past its depth, pulls a few values back, then clears.
   task automatic run_overflow_round();
      logic signed [DATA_W-1:0] cur;
      int                       lst;
      int                       n_loads;
      lst     = $urandom_range(0, NUM_LISTS - 1);
      cur     = pick_start();
      n_loads = LIST_DEPTH + $urandom_range(1, 4);
      for (int k = 0; k < n_loads; k++) begin
         cur = next_sorted(cur);
         send_request(OP_LOAD, LIST_W'(lst), cur, 1'b0, '0);
      end
      repeat ($urandom_range(1, 10)) send_request(OP_PULL, '0, $urandom, 1'b0, '0);
      send_request(OP_CLEAR, '0, '0, 1'b0, '0);
   endtask

   // Fully random requests, unused operation code included.
   task automatic run_noise_round();
      repeat ($urandom_range(5, 20)) begin
         send_request(2'($urandom_range(0, 3)), LIST_W'($urandom), $urandom, 1'b0, '0);
      end
   endtask

   // Response side: random back-pressure and in-order checking against the oldest expectation.
   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected, data %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_tdata[2:0], want.status));
            end
            if (rsp_tdata[34:3] !== want.merged_value) begin
               report_mismatch($sformatf("merged_value %0d, expected %0d",
                                         $signed(rsp_tdata[34:3]), want.merged_value));
            end
            if (rsp_tdata[37:35] !== want.source_list) begin
               report_mismatch($sformatf("source_list %0d, expected %0d",
                                         rsp_tdata[37:35], want.source_list));
            end
            case (want.status)
               ST_LOADED:  loads_seen++;
               ST_DROPPED: drops_seen++;
               ST_POPPED:  pops_seen++;
               ST_EMPTY:   empties_seen++;
               default:    clears_seen++;
            endcase
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles, %0d responses outstanding",
                  quiet_cycles, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Main sequence: reset, directed table, randomized rounds, drain and verdict.
   initial begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         fill_lvl[i] = 0;
         head_pos[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].op, directed_rows[r].list_num, directed_rows[r].value,
                      directed_rows[r].typed, directed_rows[r].res);
      end
      drain_responses();

      // The first random round always overflows a list.
      run_overflow_round();
      while (accepted_items < TARGET_ITEMS) begin
         calm = (accepted_items >= 700 && accepted_items < 1000);
         case ($urandom_range(0, 9))
            0:       run_overflow_round();
            1, 2, 3: run_noise_round();
            default: run_merge_round();
         endcase
         if ($urandom_range(0, 9) == 0) drain_responses();
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d with the unused code): %0d loads, %0d full-list drops,",
               accepted_items + ignored_items, ignored_items, loads_seen, drops_seen);
      $display("%0d merged pops, %0d pulls on empty lists, %0d clears checked.",
               pops_seen, empties_seen, clears_seen);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
